### rtl/stl_pkg.sv
// Package for the script token lexer: payload structs, token kind codes,
// result queue sizing and default limits. No dependencies.
package stl_pkg;

	// Default saturation limit for name and string lengths
	localparam int TEXT_MAX_DEF = 256;

	// Result queue sizing (depth is a power of two)
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	// Token kinds
	localparam logic [3:0] K_TEXT    = 4'd0;
	localparam logic [3:0] K_NAME    = 4'd1;
	localparam logic [3:0] K_NUMBER  = 4'd2;
	localparam logic [3:0] K_STRING  = 4'd3;
	localparam logic [3:0] K_SYMBOL  = 4'd4;
	localparam logic [3:0] K_EQ      = 4'd5;
	localparam logic [3:0] K_GE      = 4'd6;
	localparam logic [3:0] K_LE      = 4'd7;
	localparam logic [3:0] K_NEWLINE = 4'd8;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       is_end;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic [7:0]  byte_value;
		logic [47:0] mantissa;
		logic [3:0]  frac_digits;
		logic [8:0]  text_length;
		logic [19:0] line_number;
	} res_t;

	// Results pushed by one accepted item, first result in res0
	typedef struct packed {
		logic [1:0] cnt;
		res_t       res0;
		res_t       res1;
	} push_t;

endpackage

### rtl/script_token_lexer_top.sv
// Top level of the script token lexer: lexer core plus result queue.
// Depends on stl_pkg, stl_lexer, stl_res_fifo.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   in      | in        | in_valid/in_stall  | in_item  (char_byte, is_end)
//   out     | out       | out_valid/out_stall| out_item (token fields)
//   cfg     | in        | cfg_valid/cfg_ready| cfg_data (newline_tokens)
//
// One source byte is taken per cycle while in_stall is low; its results
// land in a four-entry result queue in the next cycle. A byte that
// yields two results needs two output transfers, so the single output
// port sets the sustained rate. in_stall rises while the queue holds
// more than two results. Reset returns the lexer to idle at line one,
// empties the queue and clears newline_tokens. cfg_ready is always high.
module script_token_lexer_top #(
	parameter int TEXT_MAX = stl_pkg::TEXT_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  stl_pkg::in_item_t in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output stl_pkg::res_t     out_item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);
	import stl_pkg::*;

	push_t push;
	logic  full2;
	logic  accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = full2;
	assign accept    = in_valid && !in_stall;

	// Lexer core
	stl_lexer #(
		.TEXT_MAX(TEXT_MAX)
	) u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_we (cfg_valid && cfg_ready),
		.cfg_bit(cfg_data),
		.accept (accept),
		.item   (in_item),
		.push   (push)
	);

	// Result queue
	stl_res_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full2    (full2),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

endmodule

### rtl/stl_lexer.sv
// Lexer state registers and next-state logic: one source byte per cycle
// while accept is high, up to two results per byte. Depends on stl_pkg.
module stl_lexer #(
	parameter int TEXT_MAX = stl_pkg::TEXT_MAX_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_bit,
	input  logic            accept,
	input  stl_pkg::in_item_t item,
	output stl_pkg::push_t  push
);
	import stl_pkg::*;

	localparam int CNT_W = $clog2(TEXT_MAX + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TEXT_MAX);
	localparam logic [47:0] MANT_MAX = {48{1'b1}};
	localparam logic [19:0] LINE_MAX = {20{1'b1}};

	// Scan modes
	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_NAME = 3'd1;
	localparam logic [2:0] M_INT  = 3'd2;
	localparam logic [2:0] M_FRAC = 3'd3;
	localparam logic [2:0] M_STR  = 3'd4;
	localparam logic [2:0] M_CMP  = 3'd5;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_UND   = 8'h5F;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_symbol(input logic [7:0] c);
		logic r;
		unique case (c)
			8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h2C, 8'h3B, 8'h3A,
			8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] decode_escape(input logic [7:0] c);
		logic [7:0] r;
		unique case (c)
			8'h30: r = 8'h00;
			8'h62: r = 8'h08;
			8'h6E: r = 8'h0A;
			8'h72: r = 8'h0D;
			8'h74: r = 8'h09;
			default: r = c;
		endcase
		return r;
	endfunction

	function automatic res_t mk_res(input logic [3:0] kind, input logic [7:0] b,
			input logic [47:0] mant, input logic [3:0] frac, input logic [8:0] len,
			input logic [19:0] line);
		res_t r;
		r.token_kind  = kind;
		r.byte_value  = b;
		r.mantissa    = mant;
		r.frac_digits = frac;
		r.text_length = len;
		r.line_number = line;
		return r;
	endfunction

	logic [2:0]       mode_q, mode_n;
	logic [7:0]       quote_q, quote_n;
	logic [7:0]       cmp_q, cmp_n;
	logic             esc_q, esc_n;
	logic [47:0]      digit_q, digit_n;
	logic [3:0]       frac_q, frac_n;
	logic [CNT_W-1:0] text_q, text_n;
	logic [19:0]      line_q, line_n;
	logic             nl_en_q;

	logic [7:0]       c;
	logic [51:0]      mac;
	logic [47:0]      digit_add;
	logic [CNT_W-1:0] text_inc;
	logic [3:0]       frac_inc;
	logic             run_idle;
	logic             ra_v, rb_v;
	res_t             ra, rb;

	// Next state and results for one byte
	always_comb begin
		c         = item.char_byte;
		// ten times the value plus the new digit: 8x + 2x + d
		mac       = {1'b0, digit_q, 3'b0} + {3'b0, digit_q, 1'b0} + {48'b0, c[3:0]};
		digit_add = (mac > {4'b0, MANT_MAX}) ? MANT_MAX : mac[47:0];
		text_inc  = (text_q < CNT_MAX) ? text_q + CNT_W'(1) : text_q;
		frac_inc  = (frac_q != 4'd15) ? frac_q + 4'd1 : frac_q;

		mode_n   = mode_q;
		quote_n  = quote_q;
		cmp_n    = cmp_q;
		esc_n    = esc_q;
		digit_n  = digit_q;
		frac_n   = frac_q;
		text_n   = text_q;
		line_n   = line_q;
		run_idle = 1'b0;
		ra_v     = 1'b0;
		rb_v     = 1'b0;
		ra       = mk_res(K_TEXT, 8'd0, 48'd0, 4'd0, 9'd0, line_q);
		rb       = ra;

		if (item.is_end) begin
			// flush the pending token
			unique case (mode_q)
				M_NAME: begin
					ra_v = 1'b1;
					ra   = mk_res(K_NAME, 8'd0, 48'd0, 4'd0, 9'(text_q), line_q);
				end
				M_INT, M_FRAC: begin
					ra_v = 1'b1;
					ra   = mk_res(K_NUMBER, 8'd0, digit_q, frac_q, 9'd0, line_q);
				end
				M_STR: begin
					ra_v = 1'b1;
					ra   = mk_res(K_STRING, 8'd0, 48'd0, 4'd0, 9'(text_q), line_q);
				end
				M_CMP: begin
					ra_v = 1'b1;
					ra   = mk_res(K_SYMBOL, cmp_q, 48'd0, 4'd0, 9'd0, line_q);
				end
				default: ;
			endcase
			mode_n = M_IDLE;
			esc_n  = 1'b0;
		end else begin
			// first pass in the current mode
			unique case (mode_q)
				M_NAME: begin
					if (is_letter(c) || is_digit(c) || c == CH_UND) begin
						text_n = text_inc;
						ra_v   = 1'b1;
						ra     = mk_res(K_TEXT, c, 48'd0, 4'd0, 9'd0, line_q);
					end else begin
						ra_v     = 1'b1;
						ra       = mk_res(K_NAME, 8'd0, 48'd0, 4'd0, 9'(text_q), line_q);
						run_idle = 1'b1;
					end
				end
				M_INT: begin
					if (is_digit(c)) begin
						digit_n = digit_add;
					end else if (c == CH_DOT) begin
						mode_n = M_FRAC;
					end else begin
						ra_v     = 1'b1;
						ra       = mk_res(K_NUMBER, 8'd0, digit_q, frac_q, 9'd0, line_q);
						run_idle = 1'b1;
					end
				end
				M_FRAC: begin
					if (is_digit(c)) begin
						digit_n = digit_add;
						frac_n  = frac_inc;
					end else begin
						ra_v     = 1'b1;
						ra       = mk_res(K_NUMBER, 8'd0, digit_q, frac_q, 9'd0, line_q);
						run_idle = 1'b1;
					end
				end
				M_STR: begin
					if (esc_q) begin
						esc_n  = 1'b0;
						text_n = text_inc;
						ra_v   = 1'b1;
						ra     = mk_res(K_TEXT, decode_escape(c), 48'd0, 4'd0, 9'd0, line_q);
					end else if (c == quote_q) begin
						ra_v   = 1'b1;
						ra     = mk_res(K_STRING, 8'd0, 48'd0, 4'd0, 9'(text_q), line_q);
						mode_n = M_IDLE;
					end else if (c == CH_BSL) begin
						esc_n = 1'b1;
					end else begin
						text_n = text_inc;
						ra_v   = 1'b1;
						ra     = mk_res(K_TEXT, c, 48'd0, 4'd0, 9'd0, line_q);
					end
				end
				M_CMP: begin
					mode_n = M_IDLE;
					ra_v   = 1'b1;
					if (c == CH_EQ) begin
						if (cmp_q == CH_EQ) begin
							ra = mk_res(K_EQ, 8'd0, 48'd0, 4'd0, 9'd0, line_q);
						end else if (cmp_q == CH_GT) begin
							ra = mk_res(K_GE, 8'd0, 48'd0, 4'd0, 9'd0, line_q);
						end else begin
							ra = mk_res(K_LE, 8'd0, 48'd0, 4'd0, 9'd0, line_q);
						end
					end else begin
						ra       = mk_res(K_SYMBOL, cmp_q, 48'd0, 4'd0, 9'd0, line_q);
						run_idle = 1'b1;
					end
				end
				default: run_idle = 1'b1;
			endcase

			// idle pass: first pass from idle, or the terminating byte again
			if (run_idle) begin
				mode_n = M_IDLE;
				if (c == CH_TAB || c == CH_SPACE || c == CH_CR) begin
					mode_n = M_IDLE;
				end else if (c == CH_LF) begin
					line_n = (line_q != LINE_MAX) ? line_q + 20'd1 : line_q;
					rb_v   = nl_en_q;
					rb     = mk_res(K_NEWLINE, 8'd0, 48'd0, 4'd0, 9'd0, line_n);
				end else if (is_letter(c)) begin
					mode_n = M_NAME;
					text_n = CNT_W'(1);
					rb_v   = 1'b1;
					rb     = mk_res(K_TEXT, c, 48'd0, 4'd0, 9'd0, line_q);
				end else if (is_digit(c)) begin
					mode_n  = M_INT;
					digit_n = {44'd0, c[3:0]};
					frac_n  = 4'd0;
				end else if (c == CH_DQ || c == CH_SQ) begin
					mode_n  = M_STR;
					quote_n = c;
					esc_n   = 1'b0;
					text_n  = '0;
				end else if (c == CH_EQ || c == CH_GT || c == CH_LT) begin
					mode_n = M_CMP;
					cmp_n  = c;
				end else if (is_symbol(c)) begin
					rb_v = 1'b1;
					rb   = mk_res(K_SYMBOL, c, 48'd0, 4'd0, 9'd0, line_q);
				end
			end
		end

		// compact the results, gated by the input transfer
		if (ra_v) begin
			push.res0 = ra;
			push.res1 = rb;
			push.cnt  = accept ? (rb_v ? 2'd2 : 2'd1) : 2'd0;
		end else begin
			push.res0 = rb;
			push.res1 = rb;
			push.cnt  = (accept && rb_v) ? 2'd1 : 2'd0;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			quote_q <= 8'd0;
			cmp_q   <= 8'd0;
			esc_q   <= 1'b0;
			digit_q <= 48'd0;
			frac_q  <= 4'd0;
			text_q  <= '0;
			line_q  <= 20'd1;
			nl_en_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				nl_en_q <= cfg_bit;
			end
			if (accept) begin
				mode_q  <= mode_n;
				quote_q <= quote_n;
				cmp_q   <= cmp_n;
				esc_q   <= esc_n;
				digit_q <= digit_n;
				frac_q  <= frac_n;
				text_q  <= text_n;
				line_q  <= line_n;
			end
		end
	end

endmodule

### rtl/stl_res_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per
// transfer, registered output. Depends on stl_pkg.
module stl_res_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  stl_pkg::push_t push,
	output logic           full2,
	output logic           out_valid,
	input  logic           out_stall,
	output stl_pkg::res_t  out_item
);
	import stl_pkg::*;

	res_t                mem [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] wr_q, rd_q;
	logic [RQ_CNT_W-1:0] cnt_q;
	logic                pop;

	assign pop       = out_valid && !out_stall;
	assign out_valid = (cnt_q != '0);
	assign out_item  = mem[rd_q];
	// no room for a two-result item
	assign full2     = (cnt_q > RQ_CNT_W'(RQ_DEPTH - 2));

	// Storage
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_q] <= push.res0;
		end
		if (push.cnt == 2'd2) begin
			mem[wr_q + RQ_PTR_W'(1)] <= push.res1;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + RQ_PTR_W'(push.cnt);
			rd_q  <= rd_q + RQ_PTR_W'(pop);
			cnt_q <= cnt_q + RQ_CNT_W'(push.cnt) - RQ_CNT_W'(pop);
		end
	end

endmodule

### tb/script_token_lexer_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for script_token_lexer_top: a directed table, then random
// token streams, every output transfer compared against a table entry or an in-bench
// lexer predictor. Depends on stl_pkg and the script_token_lexer_top RTL.
module script_token_lexer_top_tb;
	import stl_pkg::*;

	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int DRAIN_CYCLES = 4;
	localparam int PHASE_ITEMS  = 350;
	localparam int TEXT_LIMIT   = TEXT_MAX_DEF;
	localparam logic [47:0] MANT_TOP = '1;
	localparam logic [19:0] LINE_TOP = '1;

	// Character codes the lexer treats specially
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_DQ  = 8'h22;
	localparam logic [7:0] CH_SQ  = 8'h27;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_LT  = 8'h3C;
	localparam logic [7:0] CH_EQ  = 8'h3D;
	localparam logic [7:0] CH_GT  = 8'h3E;
	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_US  = 8'h5F;

	typedef enum logic [2:0] {SM_IDLE, SM_NAME, SM_INT, SM_FRAC, SM_STR, SM_CMP} scan_t;

	typedef struct {
		bit       is_cfg;
		bit       typed;
		in_item_t item;
		res_t     want;
	} dir_row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_stall;
	in_item_t in_item = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	res_t     out_item;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	logic     cfg_data = 1'b0;

	// Predictor state
	bit          nl_on;
	scan_t       mode;
	logic [7:0]  quote_ch;
	logic [7:0]  cmp_ch;
	bit          esc_on;
	logic [47:0] mant_acc;
	logic [3:0]  frac_cnt;
	int          txt_cnt;
	logic [19:0] line_no;

	res_t     step_out[$];
	res_t     want_tokens[$];
	in_item_t src_q[$];
	dir_row_t dir_tab[$];

	bit snd_calm = 1'b0;
	bit rcv_calm = 1'b0;
	int errors = 0;
	int n_items = 0;
	int n_checked = 0;
	int cycle_cnt = 0;

	script_token_lexer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("watchdog expired with %0d tokens outstanding", want_tokens.size());
			$display("script_token_lexer_top verification failed");
			$finish;
		end
	end

	// ---------------- lexer predictor ----------------

	function automatic void put_token(logic [3:0] k, logic [7:0] b, logic [47:0] m,
			logic [3:0] f, int len);
		res_t r;
		r.token_kind  = k;
		r.byte_value  = b;
		r.mantissa    = m;
		r.frac_digits = f;
		r.text_length = 9'(len);
		r.line_number = line_no;
		step_out.push_back(r);
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_symbol(logic [7:0] c);
		case (c)
			"+", "-", "*", "/", "%", ",", ";", ":", "(", ")", "[", "]", "{", "}": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void add_text();
		if (txt_cnt < TEXT_LIMIT)
			txt_cnt++;
	endfunction

	// Decimal fold, saturating at the top of the mantissa
	function automatic void add_digit(logic [7:0] c);
		logic [63:0] d;
		d = 64'(c - "0");
		if ({16'h0, mant_acc} > ({16'h0, MANT_TOP} - d) / 10)
			mant_acc = MANT_TOP;
		else
			mant_acc = 48'({16'h0, mant_acc} * 10 + d);
	endfunction

	function automatic logic [7:0] unescape(logic [7:0] c);
		case (c)
			"0": return 8'h00;
			"b": return 8'h08;
			"n": return CH_LF;
			"r": return CH_CR;
			"t": return CH_TAB;
			default: return c;
		endcase
	endfunction

	function automatic void idle_byte(logic [7:0] c);
		if (c == CH_TAB || c == CH_SP || c == CH_CR) begin
			return;
		end else if (c == CH_LF) begin
			if (line_no != LINE_TOP)
				line_no++;
			if (nl_on)
				put_token(K_NEWLINE, 8'h00, '0, '0, 0);
		end else if (is_letter(c)) begin
			mode = SM_NAME;
			txt_cnt = 0;
			add_text();
			put_token(K_TEXT, c, '0, '0, 0);
		end else if (is_digit(c)) begin
			mode = SM_INT;
			mant_acc = '0;
			frac_cnt = '0;
			add_digit(c);
		end else if (c == CH_DQ || c == CH_SQ) begin
			mode = SM_STR;
			quote_ch = c;
			esc_on = 1'b0;
			txt_cnt = 0;
		end else if (c == CH_EQ || c == CH_GT || c == CH_LT) begin
			mode = SM_CMP;
			cmp_ch = c;
		end else if (is_symbol(c)) begin
			put_token(K_SYMBOL, c, '0, '0, 0);
		end
	endfunction

	// One byte in the current mode; returns 1 when it closed a token and must be rerun
	function automatic bit lex_byte(logic [7:0] c);
		case (mode)
			SM_NAME: begin
				if (is_letter(c) || is_digit(c) || c == CH_US) begin
					add_text();
					put_token(K_TEXT, c, '0, '0, 0);
					return 1'b0;
				end
				put_token(K_NAME, 8'h00, '0, '0, txt_cnt);
				mode = SM_IDLE;
				return 1'b1;
			end
			SM_INT, SM_FRAC: begin
				if (is_digit(c)) begin
					add_digit(c);
					if (mode == SM_FRAC && frac_cnt != 4'hF)
						frac_cnt++;
					return 1'b0;
				end
				if (mode == SM_INT && c == CH_DOT) begin
					mode = SM_FRAC;
					return 1'b0;
				end
				put_token(K_NUMBER, 8'h00, mant_acc, frac_cnt, 0);
				mode = SM_IDLE;
				return 1'b1;
			end
			SM_STR: begin
				if (esc_on) begin
					esc_on = 1'b0;
					add_text();
					put_token(K_TEXT, unescape(c), '0, '0, 0);
				end else if (c == quote_ch) begin
					put_token(K_STRING, 8'h00, '0, '0, txt_cnt);
					mode = SM_IDLE;
				end else if (c == CH_BSL) begin
					esc_on = 1'b1;
				end else begin
					add_text();
					put_token(K_TEXT, c, '0, '0, 0);
				end
				return 1'b0;
			end
			SM_CMP: begin
				mode = SM_IDLE;
				if (c == CH_EQ) begin
					if (cmp_ch == CH_EQ)
						put_token(K_EQ, 8'h00, '0, '0, 0);
					else if (cmp_ch == CH_GT)
						put_token(K_GE, 8'h00, '0, '0, 0);
					else
						put_token(K_LE, 8'h00, '0, '0, 0);
					return 1'b0;
				end
				put_token(K_SYMBOL, cmp_ch, '0, '0, 0);
				return 1'b1;
			end
			default: begin
				mode = SM_IDLE;
				idle_byte(c);
				return 1'b0;
			end
		endcase
	endfunction

	// Full item: end marker flushes the open token, else the byte is lexed (maybe twice)
	function automatic void lex_item(in_item_t it);
		step_out.delete();
		if (it.is_end) begin
			case (mode)
				SM_NAME:         put_token(K_NAME, 8'h00, '0, '0, txt_cnt);
				SM_INT, SM_FRAC: put_token(K_NUMBER, 8'h00, mant_acc, frac_cnt, 0);
				SM_STR:          put_token(K_STRING, 8'h00, '0, '0, txt_cnt);
				SM_CMP:          put_token(K_SYMBOL, cmp_ch, '0, '0, 0);
				default: ;
			endcase
			mode = SM_IDLE;
			esc_on = 1'b0;
		end else if (lex_byte(it.char_byte)) begin
			void'(lex_byte(it.char_byte));
		end
	endfunction

	// ---------------- input side ----------------

	task automatic send_item(in_item_t it, bit typed, res_t want);
		int gap;
		gap = snd_calm ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_item = it;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		lex_item(it);
		if (typed)
			want_tokens.push_back(want);
		else
			foreach (step_out[i]) want_tokens.push_back(step_out[i]);
		n_items++;
		@(negedge clk);
	endtask

	// Hold off input until every expected token is out and the pipe has settled
	task automatic drain();
		in_valid = 1'b0;
		while (want_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_cfg(bit v);
		drain();
		cfg_data = v;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		nl_on = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// ---------------- directed table ----------------

	function automatic res_t tok(logic [3:0] k, logic [7:0] b, int len, logic [19:0] ln);
		res_t r;
		r = '0;
		r.token_kind = k;
		r.byte_value = b;
		r.text_length = 9'(len);
		r.line_number = ln;
		return r;
	endfunction

	function automatic void step(logic [7:0] c, bit e);
		dir_tab.push_back('{1'b0, 1'b0, in_item_t'({c, e}), res_t'('0)});
	endfunction

	function automatic void step_want(logic [7:0] c, bit e, res_t want);
		dir_tab.push_back('{1'b0, 1'b1, in_item_t'({c, e}), want});
	endfunction

	function automatic void set_cfg(bit v);
		dir_tab.push_back('{1'b1, 1'b0, in_item_t'({7'h0, v, 1'b0}), res_t'('0)});
	endfunction

	// ---------------- random token streams ----------------

	function automatic logic [7:0] any_letter();
		logic [7:0] base;
		base = $urandom_range(0, 1) ? 8'h61 : 8'h41;
		return base + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] any_digit();
		return 8'h30 + 8'($urandom_range(0, 9));
	endfunction

	function automatic void push_ch(logic [7:0] c);
		src_q.push_back(in_item_t'({c, 1'b0}));
	endfunction

	function automatic void push_end();
		src_q.push_back(in_item_t'({8'($urandom_range(0, 255)), 1'b1}));
	endfunction

	function automatic logic [7:0] escape_code(logic [7:0] q);
		case ($urandom_range(0, 7))
			0: return "0";
			1: return "b";
			2: return "n";
			3: return "r";
			4: return "t";
			5: return q;
			6: return CH_BSL;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Queue one token; big selects a long string, long name or long number
	task automatic gen_token(int big);
		int pick;
		int n;
		bit wide;
		logic [7:0] q;
		logic [7:0] c;
		string syms;
		syms = "+-*/%,;:()[]{}";
		pick = $urandom_range(0, 19);
		case (big)
			1: pick = 7;
			2: pick = 0;
			3: pick = 4;
			default: ;
		endcase
		if (pick <= 3) begin
			push_ch(any_letter());
			n = (big == 2) ? $urandom_range(257, 262) : $urandom_range(0, 8);
			repeat (n) begin
				case ($urandom_range(0, 3))
					0: push_ch(any_digit());
					1: push_ch(CH_US);
					default: push_ch(any_letter());
				endcase
			end
		end else if (pick <= 6) begin
			wide = (big == 3) || ($urandom_range(0, 7) == 0);
			n = wide ? $urandom_range(14, 20) : $urandom_range(1, 6);
			repeat (n) push_ch(any_digit());
			if (wide || $urandom_range(0, 1)) begin
				push_ch(CH_DOT);
				n = wide ? $urandom_range(14, 18) : $urandom_range(0, 5);
				repeat (n) push_ch(any_digit());
			end
			if ($urandom_range(0, 7) == 0)
				push_ch(CH_DOT);
		end else if (pick <= 9) begin
			q = $urandom_range(0, 1) ? CH_DQ : CH_SQ;
			push_ch(q);
			n = (big == 1) ? $urandom_range(257, 262) : $urandom_range(0, 10);
			repeat (n) begin
				if ($urandom_range(0, 4) == 0) begin
					push_ch(CH_BSL);
					push_ch(escape_code(q));
				end else begin
					c = 8'($urandom_range(0, 255));
					if (c == q || c == CH_BSL)
						c = "x";
					push_ch(c);
				end
			end
			if ($urandom_range(0, 9) == 0)
				push_end();
			else
				push_ch(q);
		end else if (pick <= 11) begin
			case ($urandom_range(0, 2))
				0: push_ch(CH_EQ);
				1: push_ch(CH_GT);
				default: push_ch(CH_LT);
			endcase
			if ($urandom_range(0, 1))
				push_ch(CH_EQ);
		end else if (pick <= 13) begin
			push_ch(syms[$urandom_range(0, syms.len() - 1)]);
		end else if (pick <= 15) begin
			case ($urandom_range(0, 3))
				0: push_ch(CH_SP);
				1: push_ch(CH_TAB);
				2: push_ch(CH_CR);
				default: push_ch(CH_LF);
			endcase
		end else if (pick == 16) begin
			push_ch(8'($urandom_range(0, 255)));
		end else if (pick == 17) begin
			push_end();
		end else begin
			push_ch(CH_LF);
		end
		if ($urandom_range(0, 1))
			push_ch(CH_SP);
	endtask

	// ---------------- output side ----------------

	function automatic void check_token(res_t got);
		res_t exp;
		n_checked++;
		if (want_tokens.size() == 0) begin
			$error("unexpected token: kind %0d byte %02h", got.token_kind, got.byte_value);
			errors++;
			return;
		end
		exp = want_tokens.pop_front();
		if (got.token_kind !== exp.token_kind) begin
			$error("token_kind: expected %0d, got %0d", exp.token_kind, got.token_kind);
			errors++;
		end
		if (got.byte_value !== exp.byte_value) begin
			$error("byte_value: expected %02h, got %02h", exp.byte_value, got.byte_value);
			errors++;
		end
		if (got.mantissa !== exp.mantissa) begin
			$error("mantissa: expected %0d, got %0d", exp.mantissa, got.mantissa);
			errors++;
		end
		if (got.frac_digits !== exp.frac_digits) begin
			$error("frac_digits: expected %0d, got %0d", exp.frac_digits, got.frac_digits);
			errors++;
		end
		if (got.text_length !== exp.text_length) begin
			$error("text_length: expected %0d, got %0d", exp.text_length, got.text_length);
			errors++;
		end
		if (got.line_number !== exp.line_number) begin
			$error("line_number: expected %0d, got %0d", exp.line_number, got.line_number);
			errors++;
		end
	endfunction

	// Receiver: check each transfer, then stall a random number of valid cycles
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				check_token(out_item);
				hold = rcv_calm ? 0 : $urandom_range(0, 19);
			end
			@(negedge clk);
			if (hold > 0) begin
				out_stall = 1'b1;
				if (out_valid)
					hold--;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// ---------------- main sequence ----------------

	initial begin
		int p;
		int sent;
		bit nl_plan [3];
		res_t none;

		none = '0;
		nl_on = 1'b0;
		mode = SM_IDLE;
		quote_ch = '0;
		cmp_ch = '0;
		esc_on = 1'b0;
		mant_acc = '0;
		frac_cnt = '0;
		txt_cnt = 0;
		line_no = 20'd1;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Newline counted silently at reset setting, then tokens turned on
		step(CH_LF, 1'b0);
		set_cfg(1'b1);
		step_want(CH_LF, 1'b0, tok(K_NEWLINE, 8'h00, 0, 3));
		// Name over letter and digit, closed by a symbol that is then rerun
		step_want("a", 1'b0, tok(K_TEXT, "a", 0, 3));
		step_want("9", 1'b0, tok(K_TEXT, "9", 0, 3));
		step("(", 1'b0);
		// Paired compares
		step(CH_GT, 1'b0);
		step_want(CH_EQ, 1'b0, tok(K_GE, 8'h00, 0, 3));
		step(CH_LT, 1'b0);
		step_want(CH_EQ, 1'b0, tok(K_LE, 8'h00, 0, 3));
		step(CH_EQ, 1'b0);
		step_want(CH_EQ, 1'b0, tok(K_EQ, 8'h00, 0, 3));
		// String: decoded escape, raw LF (no line bump), escaped quote, close
		step(CH_DQ, 1'b0);
		step(CH_BSL, 1'b0);
		step_want("n", 1'b0, tok(K_TEXT, CH_LF, 0, 3));
		step_want(CH_LF, 1'b0, tok(K_TEXT, CH_LF, 0, 3));
		step(CH_BSL, 1'b0);
		step_want(CH_DQ, 1'b0, tok(K_TEXT, CH_DQ, 0, 3));
		step_want(CH_DQ, 1'b0, tok(K_STRING, 8'h00, 3, 3));
		// Bare point is consumed, a second point ends the number and is dropped
		step("1", 1'b0);
		step(CH_DOT, 1'b0);
		step(CH_DOT, 1'b0);
		// End marker inside a string with an escape pending
		step(CH_SQ, 1'b0);
		step(CH_BSL, 1'b0);
		step_want(8'h00, 1'b1, tok(K_STRING, 8'h00, 0, 3));
		// End marker after a compare char, then one while idle
		step(CH_LT, 1'b0);
		step_want(8'hFF, 1'b1, tok(K_SYMBOL, CH_LT, 0, 3));
		step(8'hFF, 1'b1);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg)
				write_cfg(dir_tab[i].item.char_byte[0]);
			else
				send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
		end

		// Random phases, newline tokens switched between them
		nl_plan[0] = 1'b1;
		nl_plan[1] = 1'b0;
		nl_plan[2] = 1'b1;
		for (p = 0; p < 3; p++) begin
			write_cfg(nl_plan[p]);
			src_q.delete();
			gen_token(p + 1);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if (sent % 64 == 0) begin
					snd_calm = ($urandom_range(0, 2) == 0);
					rcv_calm = ($urandom_range(0, 2) == 0);
				end
				if (src_q.size() == 0)
					gen_token(0);
				send_item(src_q.pop_front(), 1'b0, none);
				sent++;
			end
			// Flush whatever token is open so the lexer sits idle
			send_item(in_item_t'({8'h00, 1'b1}), 1'b0, none);
		end

		in_valid = 1'b0;
		while (want_tokens.size() != 0) @(posedge clk);
		repeat (4 * DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d bytes and end markers, checked %0d tokens, newline tokens on and off",
			n_items, n_checked);
		if (errors == 0)
			$display("script_token_lexer_top verification clean");
		else
			$display("script_token_lexer_top verification failed");
		$finish;
	end

endmodule

### script_token_lexer_top.f
rtl/stl_pkg.sv
rtl/stl_lexer.sv
rtl/stl_res_fifo.sv
rtl/script_token_lexer_top.sv
tb/script_token_lexer_top_tb.sv
